FILE: design/tkn_pkg.sv
// ----------------------------------------------------------------------------
// tkn_pkg: shared definitions for the top-K nearest insertion list
// Constants, control codes and state types used by the cells and the top level.
// ----------------------------------------------------------------------------
package tkn_pkg;

    localparam int NUM_BEST_DEFAULT   = 5;
    localparam int INDEX_BITS_DEFAULT = 24;

    // Fixed widths of the item fields.
    localparam int DIST_BITS      = 32;
    localparam int IDX_PORT_BITS  = 24;
    localparam int RANK_BITS      = 5;

    // What every cell of the chain does; all cells share one mode.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_PUSH  = 2'd1,
        CELL_SHIFT = 2'd2
    } cell_mode_t;

    typedef enum logic {
        ST_COLLECT = 1'b0,
        ST_FLUSH   = 1'b1
    } tkn_state_t;

endpackage

FILE: design/top_k_nearest_insertion_list.sv
// Push items are taken one per cycle while s_ready is high and are written
// into the sorted chain as accepted; a push produces no item on the result side.
// A flush item emits NUM_BEST items, one per cycle while m_ready is high, via
// the output register once the FSM is in ST_FLUSH; s_ready stays low meanwhile.
// The chain shifts toward the output once per emitted item, which sets that rate.
// Synchronous active-low reset empties the list and drops any pending output.
// ----------------------------------------------------------------------------
// top_k_nearest_insertion_list: keeps the K smallest distance candidates
// A chain of NUM_BEST cells holds the list in ascending order of distance.
// ----------------------------------------------------------------------------
module top_k_nearest_insertion_list #(
    parameter int NUM_BEST   = tkn_pkg::NUM_BEST_DEFAULT,
    parameter int INDEX_BITS = tkn_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd,
    input  logic [tkn_pkg::DIST_BITS-1:0]      s_cand_dist,
    input  logic [tkn_pkg::IDX_PORT_BITS-1:0]  s_cand_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tkn_pkg::RANK_BITS-1:0]      m_rank,
    output logic [tkn_pkg::DIST_BITS-1:0]      m_best_dist,
    output logic [tkn_pkg::IDX_PORT_BITS-1:0]  m_best_index,
    output logic                               m_last
);

    localparam logic [tkn_pkg::RANK_BITS-1:0] LAST_RANK = tkn_pkg::RANK_BITS'(NUM_BEST - 1);

    tkn_pkg::tkn_state_t state_reg, state_next;
    logic [tkn_pkg::RANK_BITS-1:0] rank_reg, rank_next;
    logic                          m_valid_reg, m_valid_next;
    logic [tkn_pkg::RANK_BITS-1:0] m_rank_reg, m_rank_next;
    logic [tkn_pkg::DIST_BITS-1:0] m_dist_reg, m_dist_next;
    logic [tkn_pkg::IDX_PORT_BITS-1:0] m_index_reg, m_index_next;
    logic                          m_last_reg, m_last_next;

    tkn_pkg::cell_mode_t cell_mode;
    logic [INDEX_BITS-1:0] cand_index_w;
    logic [tkn_pkg::IDX_PORT_BITS-1:0] head_index_w;

    logic                          le_chain [NUM_BEST+1];
    logic                          fill_chain [NUM_BEST+1];
    logic [tkn_pkg::DIST_BITS-1:0] dist_chain [NUM_BEST+1];
    logic [INDEX_BITS-1:0]         index_chain [NUM_BEST+1];
    logic                          cell_filled [NUM_BEST];
    logic [tkn_pkg::DIST_BITS-1:0] cell_dist [NUM_BEST];
    logic [INDEX_BITS-1:0]         cell_index [NUM_BEST];

    generate
        if (INDEX_BITS >= tkn_pkg::IDX_PORT_BITS) begin : g_idx_wide
            assign cand_index_w = INDEX_BITS'(s_cand_index);
            assign head_index_w = cell_index[0][tkn_pkg::IDX_PORT_BITS-1:0];
        end else begin : g_idx_narrow
            assign cand_index_w = s_cand_index[INDEX_BITS-1:0];
            assign head_index_w = tkn_pkg::IDX_PORT_BITS'(cell_index[0]);
        end
    endgenerate

    // Cell 0 always has room ahead of the candidate; the tail feeds empty entries.
    assign le_chain[0]             = 1'b1;
    assign fill_chain[NUM_BEST]    = 1'b0;
    assign dist_chain[NUM_BEST]    = '1;
    assign index_chain[NUM_BEST]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_BEST; gi++) begin : g_cell
            logic                          prev_filled;
            logic [tkn_pkg::DIST_BITS-1:0] prev_dist;
            logic [INDEX_BITS-1:0]         prev_index;

            if (gi == 0) begin : g_head
                assign prev_filled = 1'b0;
                assign prev_dist   = '1;
                assign prev_index  = '0;
            end else begin : g_body
                assign prev_filled = cell_filled[gi-1];
                assign prev_dist   = cell_dist[gi-1];
                assign prev_index  = cell_index[gi-1];
            end

            tkn_cell #(
                .INDEX_BITS (INDEX_BITS)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .mode        (cell_mode),
                .cand_dist   (s_cand_dist),
                .cand_index  (cand_index_w),
                .le_in       (le_chain[gi]),
                .le_out      (le_chain[gi+1]),
                .prev_filled (prev_filled),
                .prev_dist   (prev_dist),
                .prev_index  (prev_index),
                .next_filled (fill_chain[gi+1]),
                .next_dist   (dist_chain[gi+1]),
                .next_index  (index_chain[gi+1]),
                .filled      (cell_filled[gi]),
                .slot_dist   (cell_dist[gi]),
                .index       (cell_index[gi])
            );

            assign fill_chain[gi]  = cell_filled[gi];
            assign dist_chain[gi]  = cell_dist[gi];
            assign index_chain[gi] = cell_index[gi];
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        rank_next    = rank_reg;
        m_valid_next = m_valid_reg;
        m_rank_next  = m_rank_reg;
        m_dist_next  = m_dist_reg;
        m_index_next = m_index_reg;
        m_last_next  = m_last_reg;
        cell_mode    = tkn_pkg::CELL_HOLD;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            tkn_pkg::ST_COLLECT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd) begin
                        state_next = tkn_pkg::ST_FLUSH;
                        rank_next  = '0;
                    end else begin
                        cell_mode = tkn_pkg::CELL_PUSH;
                    end
                end
            end
            tkn_pkg::ST_FLUSH: begin
                // Emit the head cell whenever the output register is empty or is being taken.
                if (!m_valid_reg || m_ready) begin
                    cell_mode    = tkn_pkg::CELL_SHIFT;
                    m_valid_next = 1'b1;
                    m_rank_next  = rank_reg;
                    m_dist_next  = cell_filled[0] ? cell_dist[0] : '1;
                    m_index_next = cell_filled[0] ? head_index_w : '0;
                    m_last_next  = (rank_reg == LAST_RANK);
                    rank_next    = rank_reg + 1'b1;
                    if (rank_reg == LAST_RANK) begin
                        state_next = tkn_pkg::ST_COLLECT;
                    end
                end
            end
            default: begin
                state_next = tkn_pkg::ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tkn_pkg::ST_COLLECT;
            rank_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rank_reg    <= rank_next;
            m_valid_reg <= m_valid_next;
        end
        m_rank_reg  <= m_rank_next;
        m_dist_reg  <= m_dist_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_rank       = m_rank_reg;
    assign m_best_dist  = m_dist_reg;
    assign m_best_index = m_index_reg;
    assign m_last       = m_last_reg;

endmodule

FILE: design/tkn_cell.sv
// ----------------------------------------------------------------------------
// tkn_cell: one slot of the sorted candidate chain
// Holds one (distance, index) entry; inserts, shifts right on insertion ahead
// of it, or shifts left toward the output during a flush.
// ----------------------------------------------------------------------------
module tkn_cell #(
    parameter int INDEX_BITS = tkn_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tkn_pkg::cell_mode_t            mode,
    input  logic [tkn_pkg::DIST_BITS-1:0]  cand_dist,
    input  logic [INDEX_BITS-1:0]          cand_index,
    input  logic                           le_in,
    output logic                           le_out,
    input  logic                           prev_filled,
    input  logic [tkn_pkg::DIST_BITS-1:0]  prev_dist,
    input  logic [INDEX_BITS-1:0]          prev_index,
    input  logic                           next_filled,
    input  logic [tkn_pkg::DIST_BITS-1:0]  next_dist,
    input  logic [INDEX_BITS-1:0]          next_index,
    output logic                           filled,
    output logic [tkn_pkg::DIST_BITS-1:0]  slot_dist,
    output logic [INDEX_BITS-1:0]          index
);

    logic                          filled_reg, filled_next;
    logic [tkn_pkg::DIST_BITS-1:0] dist_reg, dist_next;
    logic [INDEX_BITS-1:0]         index_reg, index_next;

    // Filled entries with distance not above the candidate stay ahead of it,
    // so equal distances keep arrival order.
    assign le_out = filled_reg && (dist_reg <= cand_dist);

    always_comb begin
        filled_next = filled_reg;
        dist_next   = dist_reg;
        index_next  = index_reg;
        unique case (mode)
            tkn_pkg::CELL_HOLD: begin
            end
            tkn_pkg::CELL_PUSH: begin
                if (!le_in) begin
                    // The candidate lands further up; make room for it.
                    filled_next = prev_filled;
                    dist_next   = prev_dist;
                    index_next  = prev_index;
                end else if (!le_out) begin
                    filled_next = 1'b1;
                    dist_next   = cand_dist;
                    index_next  = cand_index;
                end
            end
            tkn_pkg::CELL_SHIFT: begin
                filled_next = next_filled;
                dist_next   = next_dist;
                index_next  = next_index;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= 1'b0;
        end else begin
            filled_reg <= filled_next;
        end
        dist_reg  <= dist_next;
        index_reg <= index_next;
    end

    assign filled    = filled_reg;
    assign slot_dist = dist_reg;
    assign index     = index_reg;

endmodule
